// ===== sv/mma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_pkg
// Shared constants, state encodings and control structs of the matrix
// multiply-accumulate block.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int MAX_SIZE = 8;
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
  localparam int SIZE_W   = 4;
  localparam int FP_W     = 64;
  localparam int MANT_W   = 108;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);
  localparam logic [FP_W-1:0]   CANON_NAN  = 64'h7FF8000000000000;

  typedef enum logic {
    FOP_MUL,
    FOP_ADD
  } fpu_op_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_ALIGN,
    F_ADD,
    F_NORM,
    F_RSH,
    F_RND,
    F_DONE
  } fpu_st_e;

  typedef enum logic [3:0] {
    T_IDLE,
    T_CFETCH,
    T_CLOAD,
    T_ABFETCH,
    T_MUL,
    T_MULW,
    T_ADD,
    T_ADDW,
    T_EMIT
  } seq_st_e;

  typedef struct packed {
    logic    start;
    fpu_op_e op;
  } fpu_req_t;

  typedef struct packed {
    logic            done;
    logic [FP_W-1:0] result;
  } fpu_rsp_t;

endpackage

// ===== sv/mma_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_load_if / mma_result_if
// Valid/ready channels for load words and result words.
// ----------------------------------------------------------------------------
interface mma_load_if;
  logic                     valid;
  logic                     ready;
  logic [mma_pkg::IDX_W-1:0] row_index;
  logic [mma_pkg::IDX_W-1:0] col_index;
  logic [mma_pkg::FP_W-1:0]  a_value;
  logic [mma_pkg::FP_W-1:0]  b_value;
  logic [mma_pkg::FP_W-1:0]  c_value;
  logic                      load_last;

  modport source (output valid, row_index, col_index, a_value, b_value, c_value,
                  load_last, input ready);
  modport sink   (input valid, row_index, col_index, a_value, b_value, c_value,
                  load_last, output ready);
endinterface

interface mma_result_if;
  logic                      valid;
  logic                      ready;
  logic [mma_pkg::IDX_W-1:0] out_row;
  logic [mma_pkg::IDX_W-1:0] out_col;
  logic [mma_pkg::FP_W-1:0]  out_value;
  logic                      out_last;

  modport source (output valid, out_row, out_col, out_value, out_last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, out_last, output ready);
endinterface

// ===== sv/matrix_multiply_accumulate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// Binary64 square matrix multiply-accumulate, C += A * B.
// ----------------------------------------------------------------------------
// Load words are taken one per cycle; each writes A, B and C at its row and
// column. The word marked last starts the compute phase, during which the
// block takes no load word. For every C element the block fetches C, then, per
// k, fetches the A and B operands and runs one multiply and one add on a single
// shared floating point unit, which sets the run time, and then hands off the
// result. Infinite and NaN operands, zero products and sums of two zeros skip
// the iterative steps of an operation. Results come out in row-major order,
// the last one flagged, and are written back into C.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mma_pkg::SIZE_W-1:0]   cfg_data_i,
  mma_load_if.sink                     load_i,
  mma_result_if.source                 result_o
);

  localparam int AW = mma_pkg::ADDR_W;
  localparam int IW = mma_pkg::IDX_W;

  mma_pkg::seq_st_e         st_q, st_d;
  logic [mma_pkg::SIZE_W-1:0] size_q;
  logic [mma_pkg::SIZE_W-1:0] n_q, n_d;
  logic [IW-1:0]            i_q, i_d, j_q, j_d, k_q, k_d;
  logic [63:0]              acc_q, acc_d, prod_q, prod_d;

  logic [63:0] a_mem [mma_pkg::DEPTH];
  logic [63:0] b_mem [mma_pkg::DEPTH];
  logic [63:0] c_mem [mma_pkg::DEPTH];
  logic [63:0] a_rd_q, b_rd_q, c_rd_q;

  mma_pkg::fpu_req_t fpu_req;
  mma_pkg::fpu_rsp_t fpu_rsp;
  logic [63:0]       fpu_a, fpu_b;

  logic          ld_fire, wb_we, c_we;
  logic [AW-1:0] ld_addr, c_waddr;
  logic [63:0]   c_wdata;
  logic [mma_pkg::SIZE_W-1:0] nm1_w;
  logic [IW-1:0] nm1;
  logic          at_last;

  assign ld_fire = load_i.valid && load_i.ready;
  assign ld_addr = {load_i.row_index, load_i.col_index};
  assign nm1_w   = n_q - 4'd1;
  assign nm1     = nm1_w[IW-1:0];
  assign at_last = (i_q == nm1) && (j_q == nm1);

  always_comb begin
    st_d    = st_q;
    n_d     = n_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    wb_we   = 1'b0;
    fpu_req.start = 1'b0;
    fpu_req.op    = mma_pkg::FOP_MUL;

    case (st_q)
      mma_pkg::T_IDLE: begin
        if (ld_fire && load_i.load_last) begin
          if (size_q == '0) n_d = 4'd1;
          else if (size_q > mma_pkg::SIZE_RESET) n_d = mma_pkg::SIZE_RESET;
          else n_d = size_q;
          i_d  = '0;
          j_d  = '0;
          k_d  = '0;
          st_d = mma_pkg::T_CFETCH;
        end
      end
      mma_pkg::T_CFETCH: st_d = mma_pkg::T_CLOAD;
      mma_pkg::T_CLOAD: begin
        acc_d = c_rd_q;
        st_d  = mma_pkg::T_ABFETCH;
      end
      mma_pkg::T_ABFETCH: st_d = mma_pkg::T_MUL;
      mma_pkg::T_MUL: begin
        fpu_req.start = 1'b1;
        st_d = mma_pkg::T_MULW;
      end
      mma_pkg::T_MULW: begin
        if (fpu_rsp.done) begin
          prod_d = fpu_rsp.result;
          st_d   = mma_pkg::T_ADD;
        end
      end
      mma_pkg::T_ADD: begin
        fpu_req.start = 1'b1;
        fpu_req.op    = mma_pkg::FOP_ADD;
        st_d = mma_pkg::T_ADDW;
      end
      mma_pkg::T_ADDW: begin
        if (fpu_rsp.done) begin
          acc_d = fpu_rsp.result;
          if (k_q == nm1) begin
            wb_we = 1'b1;
            st_d  = mma_pkg::T_EMIT;
          end else begin
            k_d  = k_q + 1'b1;
            st_d = mma_pkg::T_ABFETCH;
          end
        end
      end
      mma_pkg::T_EMIT: begin
        // hold the word until taken, then advance row-major
        if (result_o.ready) begin
          k_d = '0;
          if (at_last) begin
            st_d = mma_pkg::T_IDLE;
          end else begin
            if (j_q == nm1) begin
              j_d = '0;
              i_d = i_q + 1'b1;
            end else begin
              j_d = j_q + 1'b1;
            end
            st_d = mma_pkg::T_CFETCH;
          end
        end
      end
      default: st_d = mma_pkg::T_IDLE;
    endcase
  end

  assign fpu_a = (st_q == mma_pkg::T_MUL) ? a_rd_q : acc_q;
  assign fpu_b = (st_q == mma_pkg::T_MUL) ? b_rd_q : prod_q;

  mma_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .opa_i  (fpu_a),
    .opb_i  (fpu_b),
    .rsp_o  (fpu_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= mma_pkg::T_IDLE;
      size_q <= mma_pkg::SIZE_RESET;
      n_q    <= mma_pkg::SIZE_RESET;
      i_q    <= '0;
      j_q    <= '0;
      k_q    <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) size_q <= cfg_data_i;
      n_q  <= n_d;
      i_q  <= i_d;
      j_q  <= j_d;
      k_q  <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  assign c_we    = ld_fire || wb_we;
  assign c_waddr = wb_we ? {i_q, j_q} : ld_addr;
  assign c_wdata = wb_we ? fpu_rsp.result : load_i.c_value;

  always_ff @(posedge clk_i) begin
    if (ld_fire) begin
      a_mem[ld_addr] <= load_i.a_value;
      b_mem[ld_addr] <= load_i.b_value;
    end
    if (c_we) c_mem[c_waddr] <= c_wdata;
    a_rd_q <= a_mem[{i_q, k_q}];
    b_rd_q <= b_mem[{k_q, j_q}];
    c_rd_q <= c_mem[{i_q, j_q}];
  end

  assign load_i.ready       = (st_q == mma_pkg::T_IDLE);
  assign result_o.valid     = (st_q == mma_pkg::T_EMIT);
  assign result_o.out_row   = i_q;
  assign result_o.out_col   = j_q;
  assign result_o.out_value = acc_q;
  assign result_o.out_last  = at_last;

endmodule

// ===== sv/mma_fpu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_fpu
// Iterative binary64 multiply or add, round to nearest even. One 27x27
// multiplier, one shared sticky right shifter and one normalize/round path.
// ----------------------------------------------------------------------------
module mma_fpu (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mma_pkg::fpu_req_t        req_i,
  input  logic [mma_pkg::FP_W-1:0] opa_i,
  input  logic [mma_pkg::FP_W-1:0] opb_i,
  output mma_pkg::fpu_rsp_t        rsp_o
);

  localparam int MW = mma_pkg::MANT_W;
  localparam logic [6:0] MW_AMT = 7'(MW);

  mma_pkg::fpu_st_e st_q, st_d;
  logic [2:0]           step_q, step_d;
  logic                 sgn_q, sgn_d;
  logic                 sub_q, sub_d;
  logic signed [13:0]   x_q, x_d;
  logic [MW-1:0]        m_q, m_d;
  logic [MW-1:0]        aux_q, aux_d;
  logic [MW-1:0]        pp_q, pp_d;
  logic [6:0]           amt_q, amt_d;
  logic [52:0]          pa_q, pa_d;
  logic [52:0]          pb_q, pb_d;
  logic [63:0]          res_q, res_d;

  // operand unpack
  logic [10:0] ea, eb, eae, ebe;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [52:0] ma, mb;
  always_comb begin
    ea     = opa_i[62:52];
    eb     = opb_i[62:52];
    a_nan  = (&ea) && (|opa_i[51:0]);
    b_nan  = (&eb) && (|opb_i[51:0]);
    a_inf  = (&ea) && !(|opa_i[51:0]);
    b_inf  = (&eb) && !(|opb_i[51:0]);
    a_zero = !(|opa_i[62:0]);
    b_zero = !(|opb_i[62:0]);
    ma     = {|ea, opa_i[51:0]};
    mb     = {|eb, opb_i[51:0]};
    eae    = (ea == 11'd0) ? 11'd1 : ea;
    ebe    = (eb == 11'd0) ? 11'd1 : eb;
  end

  // partial product of the current step
  logic [26:0] mul_a, mul_b;
  logic [53:0] mul_p;
  logic [6:0]  mul_sh;
  always_comb begin
    case (step_q[1:0])
      2'd0: begin mul_a = {1'b0, pa_q[25:0]}; mul_b = {1'b0, pb_q[25:0]}; mul_sh = 7'd2;  end
      2'd1: begin mul_a = {1'b0, pa_q[25:0]}; mul_b = pb_q[52:26];        mul_sh = 7'd28; end
      2'd2: begin mul_a = pa_q[52:26];        mul_b = {1'b0, pb_q[25:0]}; mul_sh = 7'd28; end
      default: begin mul_a = pa_q[52:26];     mul_b = pb_q[52:26];        mul_sh = 7'd54; end
    endcase
    mul_p = mul_a * mul_b;
  end

  // shared right shifter with sticky, used for alignment and denormalization
  logic signed [13:0] rsh_n;
  logic [6:0]         rsh_amt, sh_amt;
  logic [MW-1:0]      sh_in, sh_out;
  logic               sh_sticky;
  always_comb begin
    rsh_n   = 14'sd1 - x_q;
    rsh_amt = (rsh_n > 14'sd108) ? MW_AMT : rsh_n[6:0];
    sh_in   = (st_q == mma_pkg::F_ALIGN) ? aux_q : m_q;
    sh_amt  = (st_q == mma_pkg::F_ALIGN) ? amt_q : rsh_amt;
    sh_sticky = |(sh_in & ~({MW{1'b1}} << sh_amt));
    sh_out  = (sh_in >> sh_amt) | {{(MW-1){1'b0}}, sh_sticky};
  end

  // rounding
  logic [52:0] sig;
  logic        rnd;
  logic [13:0] xm1;
  logic [63:0] field;
  logic        ovf;
  always_comb begin
    sig   = m_q[MW-1:MW-53];
    rnd   = m_q[MW-54] && ((|m_q[MW-55:0]) || sig[0]);
    xm1   = 14'(x_q - 14'sd1);
    field = {xm1[11:0], 52'd0} + {11'd0, sig} + {63'd0, rnd};
    ovf   = field[63:52] >= 12'd2047;
  end

  logic        a_big;
  logic [10:0] e_big, e_sml, e_dif;
  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    sgn_d  = sgn_q;
    sub_d  = sub_q;
    x_d    = x_q;
    m_d    = m_q;
    aux_d  = aux_q;
    pp_d   = pp_q;
    amt_d  = amt_q;
    pa_d   = pa_q;
    pb_d   = pb_q;
    res_d  = res_q;
    a_big  = opa_i[62:0] >= opb_i[62:0];
    e_big  = a_big ? eae : ebe;
    e_sml  = a_big ? ebe : eae;
    e_dif  = e_big - e_sml;

    case (st_q)
      mma_pkg::F_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == mma_pkg::FOP_MUL) begin
            sgn_d = opa_i[63] ^ opb_i[63];
            if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
              res_d = mma_pkg::CANON_NAN;
              st_d  = mma_pkg::F_DONE;
            end else if (a_inf || b_inf) begin
              res_d = {opa_i[63] ^ opb_i[63], 11'h7FF, 52'd0};
              st_d  = mma_pkg::F_DONE;
            end else if (a_zero || b_zero) begin
              res_d = {opa_i[63] ^ opb_i[63], 63'd0};
              st_d  = mma_pkg::F_DONE;
            end else begin
              pa_d   = ma;
              pb_d   = mb;
              m_d    = '0;
              step_d = 3'd0;
              x_d    = $signed({3'b0, eae}) + $signed({3'b0, ebe}) - 14'sd1022;
              st_d   = mma_pkg::F_MUL;
            end
          end else begin
            if (a_nan || b_nan || (a_inf && b_inf && (opa_i[63] != opb_i[63]))) begin
              res_d = mma_pkg::CANON_NAN;
              st_d  = mma_pkg::F_DONE;
            end else if (a_inf) begin
              res_d = opa_i;
              st_d  = mma_pkg::F_DONE;
            end else if (b_inf) begin
              res_d = opb_i;
              st_d  = mma_pkg::F_DONE;
            end else if (a_zero && b_zero) begin
              res_d = {opa_i[63] & opb_i[63], 63'd0};
              st_d  = mma_pkg::F_DONE;
            end else begin
              sgn_d = a_big ? opa_i[63] : opb_i[63];
              sub_d = opa_i[63] ^ opb_i[63];
              m_d   = {1'b0, (a_big ? ma : mb), 54'd0};
              aux_d = {1'b0, (a_big ? mb : ma), 54'd0};
              amt_d = (e_dif > 11'd108) ? MW_AMT : e_dif[6:0];
              x_d   = $signed({3'b0, e_big}) + 14'sd1;
              st_d  = mma_pkg::F_ALIGN;
            end
          end
        end
      end
      mma_pkg::F_MUL: begin
        // product of this step goes to pp, previous one accumulates
        pp_d = {54'd0, mul_p} << mul_sh;
        if (step_q != 3'd0) m_d = m_q + pp_q;
        step_d = step_q + 3'd1;
        if (step_q == 3'd4) st_d = mma_pkg::F_NORM;
      end
      mma_pkg::F_ALIGN: begin
        aux_d = sh_out;
        st_d  = mma_pkg::F_ADD;
      end
      mma_pkg::F_ADD: begin
        m_d  = sub_q ? (m_q - aux_q) : (m_q + aux_q);
        st_d = mma_pkg::F_NORM;
      end
      mma_pkg::F_NORM: begin
        if (m_q == '0) begin
          res_d = '0;
          st_d  = mma_pkg::F_DONE;
        end else if (m_q[MW-1:MW-16] == 16'd0) begin
          m_d = m_q << 16;
          x_d = x_q - 14'sd16;
        end else if (!m_q[MW-1]) begin
          m_d = m_q << 1;
          x_d = x_q - 14'sd1;
        end else begin
          st_d = mma_pkg::F_RSH;
        end
      end
      mma_pkg::F_RSH: begin
        // drop below the normal range into a subnormal
        if (x_q <= 14'sd0) begin
          m_d = sh_out;
          x_d = 14'sd1;
        end
        st_d = mma_pkg::F_RND;
      end
      mma_pkg::F_RND: begin
        res_d = ovf ? {sgn_q, 11'h7FF, 52'd0} : {sgn_q, field[62:0]};
        st_d  = mma_pkg::F_DONE;
      end
      mma_pkg::F_DONE: begin
        st_d = mma_pkg::F_IDLE;
      end
      default: st_d = mma_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= mma_pkg::F_IDLE;
      step_q <= 3'd0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sgn_q <= sgn_d;
    sub_q <= sub_d;
    x_q   <= x_d;
    m_q   <= m_d;
    aux_q <= aux_d;
    pp_q  <= pp_d;
    amt_q <= amt_d;
    pa_q  <= pa_d;
    pb_q  <= pb_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = (st_q == mma_pkg::F_DONE);
  assign rsp_o.result = res_q;

endmodule

// ===== sv/mma_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_checker
// Port-level checks of the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
module mma_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [63:0] out_value
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result word changed while stalled");

  // no load word is taken while results are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("load ready during result phase");

  // the last load word starts compute and drops ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("load ready right after last load word");

  // nothing follows the final result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("activity after final result word");

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (load_i.valid),
  .in_ready  (load_i.ready),
  .in_last   (load_i.load_last),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .out_last  (result_o.out_last),
  .out_value (result_o.out_value)
);
